/* rtl/core/avraf_pkg.sv */
// ----------------------------------------------------------------------------
// avraf_pkg
// Shared types and constants for the add-family ALU slice.
// ----------------------------------------------------------------------------
`default_nettype none

package avraf_pkg;

  // Operation codes; codes above FUNC_INC behave as nop
  typedef enum logic [2:0] {
    FUNC_NOP  = 3'd0,
    FUNC_ADC  = 3'd1,
    FUNC_ADD  = 3'd2,
    FUNC_ADIW = 3'd3,
    FUNC_INC  = 3'd4
  } func_t;

  // Status flag bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;

  localparam int FLAGS_W = 6;
  localparam int ADDR_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int IMM_W   = 6;

  // Increment overflows only from the largest positive byte
  localparam logic [BYTE_W-1:0] INC_OVF_VALUE = 8'h7F;

  typedef struct packed {
    logic [2:0]        func;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_value;
    logic [BYTE_W-1:0] rd_high_value;
    logic [BYTE_W-1:0] rr_value;
    logic [IMM_W-1:0]  imm_k;
  } item_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  write_addr;
    logic [BYTE_W-1:0]  write_low;
    logic               write_high_enable;
    logic [ADDR_W-1:0]  write_high_addr;
    logic [BYTE_W-1:0]  write_high;
    logic [FLAGS_W-1:0] flags;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/avraf_exec.sv */
// ----------------------------------------------------------------------------
// avraf_exec
// Single-pass datapath: result bytes, addresses and new status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module avraf_exec
  import avraf_pkg::*;
(
  input  item_t              item,
  input  logic [FLAGS_W-1:0] flags_cur,
  output result_t            res
);

  logic              cin;
  logic [BYTE_W:0]   sum9;
  logic [BYTE_W-1:0] r_add;
  logic [15:0]       w_sum;
  logic [BYTE_W-1:0] r_inc;
  logic              d3, s3, r3, d7, s7, r7, dh7, wn;
  logic              c_add, h_add, v_add;
  logic              c_w, v_w, v_inc;

  always_comb begin
    cin   = (item.func == FUNC_ADC) ? flags_cur[FLAG_C] : 1'b0;
    sum9  = {1'b0, item.rd_value} + {1'b0, item.rr_value} + {{BYTE_W{1'b0}}, cin};
    r_add = sum9[BYTE_W-1:0];
    d3 = item.rd_value[3];
    s3 = item.rr_value[3];
    r3 = r_add[3];
    d7 = item.rd_value[7];
    s7 = item.rr_value[7];
    r7 = r_add[7];
    h_add = (d3 & s3) | (s3 & ~r3) | (d3 & ~r3);
    v_add = (d7 & s7 & ~r7) | (~d7 & ~s7 & r7);
    c_add = (d7 & s7) | (s7 & ~r7) | (d7 & ~r7);

    w_sum = {item.rd_high_value, item.rd_value} + {{(16-IMM_W){1'b0}}, item.imm_k};
    dh7   = item.rd_high_value[7];
    wn    = w_sum[15];
    c_w   = ~wn & dh7;
    v_w   = wn & ~dh7;

    r_inc = item.rd_value + 8'd1;
    v_inc = (item.rd_value == INC_OVF_VALUE);
  end

  always_comb begin
    res                   = '0;
    res.write_addr        = item.rd_addr;
    res.write_high_addr   = item.rd_addr + 5'd1;
    res.flags             = flags_cur;
    unique case (item.func)
      FUNC_ADC, FUNC_ADD: begin
        res.write_enable  = 1'b1;
        res.write_low     = r_add;
        res.flags[FLAG_C] = c_add;
        res.flags[FLAG_Z] = (r_add == '0);
        res.flags[FLAG_N] = r7;
        res.flags[FLAG_V] = v_add;
        res.flags[FLAG_S] = r7 ^ v_add;
        res.flags[FLAG_H] = h_add;
      end
      FUNC_ADIW: begin
        res.write_enable      = 1'b1;
        res.write_low         = w_sum[7:0];
        res.write_high_enable = 1'b1;
        res.write_high        = w_sum[15:8];
        res.flags[FLAG_C]     = c_w;
        res.flags[FLAG_Z]     = (w_sum == '0);
        res.flags[FLAG_N]     = wn;
        res.flags[FLAG_V]     = v_w;
        res.flags[FLAG_S]     = wn ^ v_w;
      end
      FUNC_INC: begin
        res.write_enable  = 1'b1;
        res.write_low     = r_inc;
        res.flags[FLAG_Z] = (r_inc == '0);
        res.flags[FLAG_N] = r_inc[7];
        res.flags[FLAG_V] = v_inc;
        res.flags[FLAG_S] = r_inc[7] ^ v_inc;
      end
      default: begin
        // nop and unused codes: nothing written, flags kept
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/avr_add_alu_flags.sv */
// ----------------------------------------------------------------------------
// avr_add_alu_flags
// Add-family ALU slice (ADC, ADD, ADIW, INC) with the arithmetic status flags.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | func, rd_addr, rd_value, rd_high_value,
//          |                      | rr_value, imm_k
//  out     | out_valid / out_ready| write_enable, write_addr, write_low,
//          |                      | write_high_enable, write_high_addr,
//          |                      | write_high, flags
//
//  One transaction per cycle sustained while out_ready is high; an accepted
//  transaction is held in the input register, then loaded into the result
//  register, when out_valid rises.
//  The status flags live in the result register's flags field: it loads only
//  when a transaction moves into the result register, so the next item sees
//  the flags of the one before it without a bubble.
//  Reset clears both valid bits and the status flags.
//  A stall on out propagates back through in_ready in the same cycle; no
//  transaction is dropped or duplicated.
// ----------------------------------------------------------------------------
`default_nettype none

module avr_add_alu_flags
  import avraf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [ADDR_W-1:0]  rd_addr,
  input  logic [BYTE_W-1:0]  rd_value,
  input  logic [BYTE_W-1:0]  rd_high_value,
  input  logic [BYTE_W-1:0]  rr_value,
  input  logic [IMM_W-1:0]   imm_k,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_enable,
  output logic [ADDR_W-1:0]  write_addr,
  output logic [BYTE_W-1:0]  write_low,
  output logic               write_high_enable,
  output logic [ADDR_W-1:0]  write_high_addr,
  output logic [BYTE_W-1:0]  write_high,
  output logic [FLAGS_W-1:0] flags
);

  // Input register stage
  logic    s1_valid;
  item_t   s1_item;
  // Result register stage; res_q.flags doubles as the status flag store
  logic    res_valid;
  result_t res_q;
  result_t res_next;

  logic    res_free;  // result register can take a transaction this cycle
  logic    s1_move;   // stage 1 transaction moves into the result register

  assign res_free = !res_valid || out_ready;
  assign s1_move  = s1_valid && res_free;
  assign in_ready = !s1_valid || res_free;

  avraf_exec u_exec (
    .item      (s1_item),
    .flags_cur (res_q.flags),
    .res       (res_next)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (res_free) begin
        res_valid <= s1_valid;
      end
    end
  end

  // Input payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.func          <= func;
      s1_item.rd_addr       <= rd_addr;
      s1_item.rd_value      <= rd_value;
      s1_item.rd_high_value <= rd_high_value;
      s1_item.rr_value      <= rr_value;
      s1_item.imm_k         <= imm_k;
    end
  end

  // Result payload; flags need a reset as they are architectural state
  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_q.write_enable      <= res_next.write_enable;
      res_q.write_addr        <= res_next.write_addr;
      res_q.write_low         <= res_next.write_low;
      res_q.write_high_enable <= res_next.write_high_enable;
      res_q.write_high_addr   <= res_next.write_high_addr;
      res_q.write_high        <= res_next.write_high;
    end
    if (rst) begin
      res_q.flags <= '0;
    end else if (s1_move) begin
      res_q.flags <= res_next.flags;
    end
  end

  assign out_valid         = res_valid;
  assign write_enable      = res_q.write_enable;
  assign write_addr        = res_q.write_addr;
  assign write_low         = res_q.write_low;
  assign write_high_enable = res_q.write_high_enable;
  assign write_high_addr   = res_q.write_high_addr;
  assign write_high        = res_q.write_high;
  assign flags             = res_q.flags;

`ifndef SYNTHESIS
  // A held stage 1 transaction must still be there next cycle
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !res_free |=> s1_valid)
    else $error("stage 1 transaction lost while stalled");

  // Flags change only when a transaction enters the result register
  a_flags_stable: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> $stable(flags))
    else $error("status flags changed without a transaction");

  // High byte write only ever comes with the low byte write
  a_high_implies_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_high_enable |-> write_enable)
    else $error("high byte written without low byte");

  // High address is the low address plus one, wrapping
  a_high_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> write_high_addr == ADDR_W'(write_addr + 5'd1))
    else $error("high write address not low address plus one");
`endif

endmodule

`default_nettype wire

/* tb/add_flags_sb_pkg.sv */
// ----------------------------------------------------------------------------
// add_flags_sb_pkg
// Scoreboard for the add-family ALU slice: keeps its own status register,
// predicts each write-back and compares it with what the block produces.
// ----------------------------------------------------------------------------
package add_flags_sb_pkg;

  import avraf_pkg::*;

  class add_flags_scoreboard;

    logic [FLAGS_W-1:0] status;
    result_t            expected_writebacks[$];
    int unsigned        mismatches;
    int unsigned        writebacks_checked;
    int unsigned        ops_seen[8];

    function new();
      status             = '0;
      mismatches         = 0;
      writebacks_checked = 0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
    endfunction

    // Write-back and new flags for one operation; advances the status copy
    function result_t predict_writeback(item_t op);
      result_t    wb;
      logic [7:0] res;
      logic [15:0] word;
      logic       cin, c, z, n, v, s, h, d3, s3, r3, d7, s7, r7, dh7;
      logic       alters_flags;
      wb                 = '0;
      wb.write_addr      = op.rd_addr;
      wb.write_high_addr = op.rd_addr + 5'd1;   // wraps at the top register
      c                  = status[FLAG_C];
      h                  = status[FLAG_H];
      z                  = status[FLAG_Z];
      n                  = status[FLAG_N];
      v                  = status[FLAG_V];
      s                  = status[FLAG_S];
      alters_flags       = 1'b1;
      case (op.func)
        FUNC_ADC, FUNC_ADD: begin
          cin = (op.func == FUNC_ADC) ? c : 1'b0;
          res = op.rd_value + op.rr_value + {7'd0, cin};
          d3  = op.rd_value[3];
          s3  = op.rr_value[3];
          r3  = res[3];
          d7  = op.rd_value[7];
          s7  = op.rr_value[7];
          r7  = res[7];
          h   = (d3 & s3) | (s3 & ~r3) | (d3 & ~r3);
          v   = (d7 & s7 & ~r7) | (~d7 & ~s7 & r7);
          c   = (d7 & s7) | (s7 & ~r7) | (d7 & ~r7);
          n   = r7;
          z   = (res == 8'h00);
          wb.write_enable = 1'b1;
          wb.write_low    = res;
        end
        FUNC_ADIW: begin
          word = {op.rd_high_value, op.rd_value} + {10'd0, op.imm_k};
          dh7  = op.rd_high_value[7];
          n    = word[15];
          z    = (word == 16'h0000);
          c    = ~n & dh7;
          v    = n & ~dh7;
          wb.write_enable      = 1'b1;
          wb.write_low         = word[7:0];
          wb.write_high_enable = 1'b1;
          wb.write_high        = word[15:8];
        end
        FUNC_INC: begin
          res = op.rd_value + 8'd1;
          v   = (op.rd_value == INC_OVF_VALUE);
          n   = res[7];
          z   = (res == 8'h00);
          wb.write_enable = 1'b1;
          wb.write_low    = res;
        end
        default: alters_flags = 1'b0;   // nop and the spare codes
      endcase
      if (alters_flags) begin
        s              = n ^ v;
        status[FLAG_C] = c;
        status[FLAG_Z] = z;
        status[FLAG_N] = n;
        status[FLAG_V] = v;
        status[FLAG_S] = s;
        status[FLAG_H] = h;
      end
      wb.flags = status;
      return wb;
    endfunction

    function void note_operands(item_t op);
      ops_seen[op.func]++;
      expected_writebacks.push_back(predict_writeback(op));
    endfunction

    function bit field_differs(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_writeback(result_t got);
      result_t want;
      bit      bad;
      if (expected_writebacks.size() == 0) begin
        $error("write-back transaction with no operation outstanding");
        mismatches++;
        return;
      end
      want = expected_writebacks.pop_front();
      writebacks_checked++;
      bad = 1'b0;
      bad |= field_differs("write_enable", want.write_enable, got.write_enable);
      bad |= field_differs("write_addr", want.write_addr, got.write_addr);
      bad |= field_differs("write_low", want.write_low, got.write_low);
      bad |= field_differs("write_high_enable", want.write_high_enable,
                           got.write_high_enable);
      bad |= field_differs("write_high_addr", want.write_high_addr,
                           got.write_high_addr);
      bad |= field_differs("write_high", want.write_high, got.write_high);
      bad |= field_differs("flags", want.flags, got.flags);
      if (bad) mismatches++;
    endfunction

  endclass

endpackage

/* tb/tb_avr_add_alu_flags.sv */
// ----------------------------------------------------------------------------
// tb_avr_add_alu_flags
// Self-checking bench for the add-family ALU slice. A directed burst hits the
// flag corners (carry chains, overflow, zero, half carry, word add wrap) and
// the nop/spare codes, then random operations run under three idle profiles
// on the two valid/ready channels; every write-back is scored on the fly.
// ----------------------------------------------------------------------------
module tb_avr_add_alu_flags;

  timeunit 1ns;
  timeprecision 1ps;

  import avraf_pkg::*;
  import add_flags_sb_pkg::*;

  localparam int RANDOM_PER_PROFILE = 545;

  logic               clk;
  logic               rst = 1'b1;

  // operand side
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         func = FUNC_NOP;
  logic [ADDR_W-1:0]  rd_addr = '0;
  logic [BYTE_W-1:0]  rd_value = '0;
  logic [BYTE_W-1:0]  rd_high_value = '0;
  logic [BYTE_W-1:0]  rr_value = '0;
  logic [IMM_W-1:0]   imm_k = '0;

  // write-back side
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               write_enable;
  logic [ADDR_W-1:0]  write_addr;
  logic [BYTE_W-1:0]  write_low;
  logic               write_high_enable;
  logic [ADDR_W-1:0]  write_high_addr;
  logic [BYTE_W-1:0]  write_high;
  logic [FLAGS_W-1:0] flags;

  // percentage of cycles each side holds back
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;

  add_flags_scoreboard sb;

  avr_add_alu_flags uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .rd_addr           (rd_addr),
    .rd_value          (rd_value),
    .rd_high_value     (rd_high_value),
    .rr_value          (rr_value),
    .imm_k             (imm_k),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .write_enable      (write_enable),
    .write_addr        (write_addr),
    .write_low         (write_low),
    .write_high_enable (write_high_enable),
    .write_high_addr   (write_high_addr),
    .write_high        (write_high),
    .flags             (flags)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver back-pressure: one decision per edge, never two writes a step
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: values read here are the ones the block saw at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_operands('{func, rd_addr, rd_value, rd_high_value, rr_value, imm_k});
      if (out_valid && out_ready)
        sb.check_writeback('{write_enable, write_addr, write_low, write_high_enable,
                             write_high_addr, write_high, flags});
    end
  end

  // Present one operation and hold it until the transaction completes.
  // Idle gaps go in front, so valid is never dropped and re-raised in a step.
  task automatic drive_op(input item_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= op.func;
    rd_addr       <= op.rd_addr;
    rd_value      <= op.rd_value;
    rd_high_value <= op.rd_high_value;
    rr_value      <= op.rr_value;
    imm_k         <= op.imm_k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic directed_op(input logic [2:0] f, input logic [ADDR_W-1:0] a,
                             input logic [BYTE_W-1:0] rd, input logic [BYTE_W-1:0] rdh,
                             input logic [BYTE_W-1:0] rr, input logic [IMM_W-1:0] k);
    drive_op('{f, a, rd, rdh, rr, k});
  endtask

  // Sender goes quiet until every write-back owed has been taken
  task automatic drain_writebacks();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_writebacks.size() != 0) @(posedge clk);
  endtask

  // Bytes lean towards the values where carries and overflow flip
  function automatic logic [BYTE_W-1:0] operand_byte();
    logic [BYTE_W-1:0] corners [6] = '{8'h00, 8'h0F, 8'h7F, 8'h80, 8'hF0, 8'hFF};
    if ($urandom_range(99) < 25)
      return corners[$urandom_range(5)];
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic item_t random_op();
    item_t       op;
    int unsigned pick;
    pick = $urandom_range(99);
    // mostly real arithmetic; a trickle of nop and spare codes
    if (pick < 6)
      op.func = 3'($urandom_range(int'(FUNC_INC) + 1, 7));
    else if (pick < 10)
      op.func = FUNC_NOP;
    else if (pick < 40)
      op.func = FUNC_ADC;   // carry chains need a good share of these
    else if (pick < 60)
      op.func = FUNC_ADD;
    else if (pick < 80)
      op.func = FUNC_ADIW;
    else
      op.func = FUNC_INC;
    op.rd_addr       = ADDR_W'($urandom_range(31));
    op.rd_value      = operand_byte();
    op.rd_high_value = operand_byte();
    op.rr_value      = operand_byte();
    op.imm_k         = IMM_W'($urandom_range(63));
    return op;
  endfunction

  initial begin
    int unsigned profile_send [3] = '{12, 48, 0};
    int unsigned profile_recv [3] = '{48, 12, 0};
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // -- directed corners, no idling either side
    directed_op(FUNC_NOP,  5'd0,  8'h00, 8'h00, 8'h00, 6'd0);
    directed_op(FUNC_NOP,  5'd31, 8'hFF, 8'hFF, 8'hFF, 6'd63);
    // spare codes must act as nop
    for (int f = int'(FUNC_INC) + 1; f < 8; f++)
      directed_op(3'(f), 5'd17, 8'hA5, 8'h5A, 8'hC3, 6'd21);
    directed_op(FUNC_ADD,  5'd0,  8'h00, 8'h00, 8'h00, 6'd0);   // zero result
    directed_op(FUNC_ADD,  5'd1,  8'hFF, 8'h00, 8'h01, 6'd0);   // carry, zero, half carry
    directed_op(FUNC_ADC,  5'd2,  8'h00, 8'h00, 8'h00, 6'd0);   // consumes that carry
    directed_op(FUNC_ADD,  5'd3,  8'h7F, 8'h00, 8'h01, 6'd0);   // signed overflow up
    directed_op(FUNC_ADD,  5'd4,  8'h80, 8'h00, 8'h80, 6'd0);   // overflow down, carry
    directed_op(FUNC_ADC,  5'd5,  8'hFF, 8'h00, 8'h00, 6'd0);   // carry ripples through
    directed_op(FUNC_ADC,  5'd6,  8'h0F, 8'h00, 8'h0F, 6'd0);
    directed_op(FUNC_INC,  5'd7,  8'h7F, 8'h00, 8'h00, 6'd0);   // inc overflow
    directed_op(FUNC_INC,  5'd8,  8'hFF, 8'h00, 8'h00, 6'd0);   // inc to zero, C kept
    directed_op(FUNC_INC,  5'd9,  8'h80, 8'h00, 8'h00, 6'd0);
    directed_op(FUNC_ADIW, 5'd24, 8'hFF, 8'hFF, 8'h00, 6'd1);   // word wraps to zero
    directed_op(FUNC_ADIW, 5'd31, 8'hC1, 8'h7F, 8'h00, 6'd63);  // top register, overflow
    directed_op(FUNC_ADIW, 5'd26, 8'h00, 8'h80, 8'h00, 6'd0);
    directed_op(FUNC_ADIW, 5'd28, 8'h3F, 8'h00, 8'h00, 6'd63);
    directed_op(FUNC_ADC,  5'd30, 8'h80, 8'h00, 8'h7F, 6'd0);
    directed_op(FUNC_ADD,  5'd31, 8'h08, 8'h00, 8'h08, 6'd0);   // half carry only
    drain_writebacks();

    // -- random traffic under each idle profile, quiet gap between profiles
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = profile_send[p];
      recv_idle_pct = profile_recv[p];
      repeat (RANDOM_PER_PROFILE) drive_op(random_op());
      drain_writebacks();
    end

    // leave a margin for stray transactions
    repeat (8) @(posedge clk);

    $display("Ops: nop %0d, adc %0d, add %0d, adiw %0d, inc %0d, spare %0d",
             sb.ops_seen[FUNC_NOP], sb.ops_seen[FUNC_ADC], sb.ops_seen[FUNC_ADD],
             sb.ops_seen[FUNC_ADIW], sb.ops_seen[FUNC_INC],
             sb.ops_seen[5] + sb.ops_seen[6] + sb.ops_seen[7]);
    $display("%0d write-backs scored over three stall profiles, %0d mismatched",
             sb.writebacks_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_writebacks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legitimate run
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
